// ===== hdl/tbpq_pkg.sv =====
// Types, constants and sizes shared by the three-band priority queue.
`timescale 1ns / 1ps

package tbpq_pkg;

  // Storage geometry
  localparam int FIFO_DEPTH = 128;
  localparam int NUM_BANDS  = 3;
  localparam int STORE_DEPTH = NUM_BANDS * FIFO_DEPTH;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Field widths
  localparam int BAND_W      = 2;
  localparam int FUNC_W      = 2;
  localparam int TOS_W       = 8;
  localparam int DSCP_W      = 6;
  localparam int PKT_W       = 16;
  localparam int LIMIT_W     = 8;
  localparam int COUNT_OUT_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_DSCP_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LIMIT = 1'd1;
  localparam logic                 DSCP_MODE_RST  = 1'b1;
  localparam logic [LIMIT_W-1:0]   BAND_LIMIT_RST = 8'd100;

  // Band numbers
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd2;

  // Request kinds; the spare code behaves as a peek
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_PEEK = 2'd2
  } tbpq_func_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_ITEM     = 2'd2,
    ST_EMPTY    = 2'd3
  } tbpq_status_e;

  // TOS byte values
  localparam logic [TOS_W-1:0] TOS_MIN_DELAY_A = 8'h10;
  localparam logic [TOS_W-1:0] TOS_MIN_DELAY_B = 8'h12;
  localparam logic [TOS_W-1:0] TOS_MIN_DELAY_C = 8'h14;
  localparam logic [TOS_W-1:0] TOS_MIN_DELAY_D = 8'h16;
  localparam logic [TOS_W-1:0] TOS_MIN_COST    = 8'h02;
  localparam logic [TOS_W-1:0] TOS_MAX_THRU_A  = 8'h08;
  localparam logic [TOS_W-1:0] TOS_MAX_THRU_B  = 8'h0a;
  localparam logic [TOS_W-1:0] TOS_MAX_THRU_C  = 8'h0c;
  localparam logic [TOS_W-1:0] TOS_MAX_THRU_D  = 8'h0e;

  // DSCP code points, named by their value
  localparam logic [DSCP_W-1:0] DSCP_CP8  = 6'd8;
  localparam logic [DSCP_W-1:0] DSCP_CP10 = 6'd10;
  localparam logic [DSCP_W-1:0] DSCP_CP12 = 6'd12;
  localparam logic [DSCP_W-1:0] DSCP_CP18 = 6'd18;
  localparam logic [DSCP_W-1:0] DSCP_CP20 = 6'd20;
  localparam logic [DSCP_W-1:0] DSCP_CP26 = 6'd26;
  localparam logic [DSCP_W-1:0] DSCP_CP28 = 6'd28;
  localparam logic [DSCP_W-1:0] DSCP_CP32 = 6'd32;
  localparam logic [DSCP_W-1:0] DSCP_CP34 = 6'd34;
  localparam logic [DSCP_W-1:0] DSCP_CP36 = 6'd36;
  localparam logic [DSCP_W-1:0] DSCP_CP40 = 6'd40;
  localparam logic [DSCP_W-1:0] DSCP_CP48 = 6'd48;
  localparam logic [DSCP_W-1:0] DSCP_CP56 = 6'd56;

  // Store access issued by the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PKT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tbpq_mem_req_t;

  // One result transaction
  typedef struct packed {
    tbpq_status_e           status;
    logic [BAND_W-1:0]      band;
    logic [PKT_W-1:0]       packet_out;
    logic [COUNT_OUT_W-1:0] count_band0;
    logic [COUNT_OUT_W-1:0] count_band1;
    logic [COUNT_OUT_W-1:0] count_band2;
  } tbpq_result_t;

endpackage

// ===== hdl/three_band_priority_queue_unit.sv =====
// Top level of the three-band strict-priority packet queue.
//
// Requests arrive on the s_axis channel: tuser carries the request kind
// (enqueue, dequeue, peek), tdata the IPv4 flag, TOS byte and packet handle.
// Each request yields exactly one result on the m_axis channel: tuser carries
// the status, tdata the band, returned handle and the three band fill counts.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// (index 0: DSCP mode, index 1: band limit); the user must do so only while
// the queue is idle, the block itself does not enforce it. One request is
// taken per cycle while s_axis_tready is high; its result passes through the
// read stage and the result register before it is valid. Pointer and count
// updates complete in the accept cycle, where the packet store read is also
// issued; the store's single read port returns the data in the next cycle.
// A result register and a read stage sit in front of the output, so a new
// request is taken while a finished result waits.
// When the receiver stalls, both stages fill and s_axis_tready drops.
// Reset empties all three bands and restores DSCP mode and a limit of 100;
// the packet store itself is not cleared, only counted entries are read.
`timescale 1ns / 1ps

module three_band_priority_queue_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tbpq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // is_ipv4, tos, packet_id
  input  logic [tbpq_pkg::FUNC_W-1:0]           s_axis_tuser,  // func
  // Result channel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // band, packet_out, count_band0, count_band1, count_band2
  output logic [tbpq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                            m_axis_tuser,  // status
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [tbpq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tbpq_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic                          dscp_mode_q;
  logic [tbpq_pkg::LIMIT_W-1:0]  band_limit_q;
  logic                          accept;
  logic                          s1_advance;
  logic                          s1_valid_q;
  tbpq_pkg::tbpq_result_t        s1_res_q;
  tbpq_pkg::tbpq_result_t        s1_res;
  logic                          out_valid_q;
  tbpq_pkg::tbpq_result_t        out_q;
  tbpq_pkg::tbpq_result_t        ctrl_res;
  tbpq_pkg::tbpq_mem_req_t       mem_req;
  logic [tbpq_pkg::BAND_W-1:0]   enq_band;
  logic [tbpq_pkg::PKT_W-1:0]    rdata;
  logic                          in_is_ipv4;
  logic [tbpq_pkg::TOS_W-1:0]    in_tos;
  logic [tbpq_pkg::PKT_W-1:0]    in_packet_id;

  // Unpack the request transaction
  assign in_is_ipv4   = s_axis_tdata[0];
  assign in_tos       = s_axis_tdata[tbpq_pkg::TOS_W:1];
  assign in_packet_id = s_axis_tdata[tbpq_pkg::TOS_W + tbpq_pkg::PKT_W:tbpq_pkg::TOS_W + 1];

  // Handshake: the read stage moves on when the result register is free
  assign s1_advance    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dscp_mode_q  <= tbpq_pkg::DSCP_MODE_RST;
      band_limit_q <= tbpq_pkg::BAND_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tbpq_pkg::CFG_DSCP_MODE) begin
        dscp_mode_q <= cfg_data_i[0];
      end else if (cfg_idx_i == tbpq_pkg::CFG_BAND_LIMIT) begin
        band_limit_q <= cfg_data_i[tbpq_pkg::LIMIT_W-1:0];
      end
    end
  end

  tbpq_classify u_classify (
    .dscp_mode_i (dscp_mode_q),
    .is_ipv4_i   (in_is_ipv4),
    .tos_i       (in_tos),
    .band_o      (enq_band)
  );

  tbpq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (s_axis_tuser),
    .band_i       (enq_band),
    .packet_id_i  (in_packet_id),
    .band_limit_i (band_limit_q),
    .mem_req_o    (mem_req),
    .result_o     (ctrl_res)
  );

  tbpq_ram #(
    .DEPTH (tbpq_pkg::STORE_DEPTH),
    .WIDTH (tbpq_pkg::PKT_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Read stage: hold the decision while the store read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= ctrl_res;
    end
  end

  // Merge the returned handle into the result
  always_comb begin
    s1_res = s1_res_q;
    if (s1_res_q.status == tbpq_pkg::ST_ITEM) begin
      s1_res.packet_out = rdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      out_q <= s1_res;
    end
  end

  // Pack the result transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'd0, out_q.count_band2, out_q.count_band1, out_q.count_band0,
                          out_q.packet_out, out_q.band};

endmodule

// ===== hdl/tbpq_classify.sv =====
// Band classifier: maps an IPv4 TOS byte or DSCP code point to a band.
`timescale 1ns / 1ps

module tbpq_classify (
  input  logic                            dscp_mode_i,
  input  logic                            is_ipv4_i,
  input  logic [tbpq_pkg::TOS_W-1:0]      tos_i,
  output logic [tbpq_pkg::BAND_W-1:0]     band_o
);

  logic [tbpq_pkg::DSCP_W-1:0] dscp;
  logic [tbpq_pkg::BAND_W-1:0] tos_band;
  logic [tbpq_pkg::BAND_W-1:0] dscp_band;

  assign dscp = tos_i[tbpq_pkg::TOS_W-1 -: tbpq_pkg::DSCP_W];

  // Map the whole TOS byte
  always_comb begin
    unique case (tos_i) inside
      tbpq_pkg::TOS_MIN_DELAY_A, tbpq_pkg::TOS_MIN_DELAY_B,
      tbpq_pkg::TOS_MIN_DELAY_C, tbpq_pkg::TOS_MIN_DELAY_D: tos_band = tbpq_pkg::BAND_HIGH;
      tbpq_pkg::TOS_MIN_COST, tbpq_pkg::TOS_MAX_THRU_A, tbpq_pkg::TOS_MAX_THRU_B,
      tbpq_pkg::TOS_MAX_THRU_C, tbpq_pkg::TOS_MAX_THRU_D: tos_band = tbpq_pkg::BAND_LOW;
      default: tos_band = tbpq_pkg::BAND_MID;
    endcase
  end

  // Map the DSCP code point
  always_comb begin
    unique case (dscp) inside
      tbpq_pkg::DSCP_CP12, tbpq_pkg::DSCP_CP20, tbpq_pkg::DSCP_CP28, tbpq_pkg::DSCP_CP36,
      tbpq_pkg::DSCP_CP32, tbpq_pkg::DSCP_CP40, tbpq_pkg::DSCP_CP48,
      tbpq_pkg::DSCP_CP56: dscp_band = tbpq_pkg::BAND_HIGH;
      tbpq_pkg::DSCP_CP10, tbpq_pkg::DSCP_CP18, tbpq_pkg::DSCP_CP26, tbpq_pkg::DSCP_CP34,
      tbpq_pkg::DSCP_CP8: dscp_band = tbpq_pkg::BAND_LOW;
      default: dscp_band = tbpq_pkg::BAND_MID;
    endcase
  end

  // Non-IPv4 traffic always goes to the middle band
  always_comb begin
    if (!is_ipv4_i) begin
      band_o = tbpq_pkg::BAND_MID;
    end else if (dscp_mode_i) begin
      band_o = dscp_band;
    end else begin
      band_o = tos_band;
    end
  end

endmodule

// ===== hdl/tbpq_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tbpq_ram #(
  parameter int DEPTH = 384,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tbpq_ctrl.sv =====
// Queue controller: per-band head pointers and fill counts, store access decisions.
`timescale 1ns / 1ps

module tbpq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [tbpq_pkg::FUNC_W-1:0]      func_i,
  input  logic [tbpq_pkg::BAND_W-1:0]      band_i,
  input  logic [tbpq_pkg::PKT_W-1:0]       packet_id_i,
  input  logic [tbpq_pkg::LIMIT_W-1:0]     band_limit_i,
  output tbpq_pkg::tbpq_mem_req_t          mem_req_o,
  output tbpq_pkg::tbpq_result_t           result_o
);

  localparam int CMP_W = (tbpq_pkg::CNT_W > tbpq_pkg::LIMIT_W) ?
                         tbpq_pkg::CNT_W : tbpq_pkg::LIMIT_W;
  localparam int SUM_W = tbpq_pkg::CNT_W + 1;

  logic [tbpq_pkg::PTR_W-1:0]  head_q [tbpq_pkg::NUM_BANDS];
  logic [tbpq_pkg::PTR_W-1:0]  head_d [tbpq_pkg::NUM_BANDS];
  logic [tbpq_pkg::CNT_W-1:0]  fill_q [tbpq_pkg::NUM_BANDS];
  logic [tbpq_pkg::CNT_W-1:0]  fill_d [tbpq_pkg::NUM_BANDS];
  logic [tbpq_pkg::ADDR_W-1:0] lane_waddr [tbpq_pkg::NUM_BANDS];
  logic [tbpq_pkg::ADDR_W-1:0] lane_raddr [tbpq_pkg::NUM_BANDS];
  logic [SUM_W-1:0]            lane_sum   [tbpq_pkg::NUM_BANDS];
  logic [SUM_W-1:0]            lane_pos   [tbpq_pkg::NUM_BANDS];
  logic                        lane_full  [tbpq_pkg::NUM_BANDS];
  logic [CMP_W-1:0]            limit_c;
  logic                        serve_found;
  logic [tbpq_pkg::BAND_W-1:0] serve_band;
  logic                        enq_full;
  logic [tbpq_pkg::ADDR_W-1:0] enq_addr;
  logic [tbpq_pkg::ADDR_W-1:0] serve_addr;
  logic                        is_enq;
  logic                        is_deq;

  assign is_enq = (func_i == tbpq_pkg::FUNC_ENQ);
  assign is_deq = (func_i == tbpq_pkg::FUNC_DEQ);

  // Clamp the configured limit to the band depth
  always_comb begin
    if (CMP_W'(band_limit_i) > CMP_W'(tbpq_pkg::FIFO_DEPTH)) begin
      limit_c = CMP_W'(tbpq_pkg::FIFO_DEPTH);
    end else begin
      limit_c = CMP_W'(band_limit_i);
    end
  end

  // Per-band tail address, head address and full flag
  always_comb begin
    for (int b = 0; b < tbpq_pkg::NUM_BANDS; b++) begin
      lane_full[b] = (CMP_W'(fill_q[b]) >= limit_c);
      lane_sum[b]  = SUM_W'(head_q[b]) + SUM_W'(fill_q[b]);
      if (lane_sum[b] >= SUM_W'(tbpq_pkg::FIFO_DEPTH)) begin
        lane_pos[b] = lane_sum[b] - SUM_W'(tbpq_pkg::FIFO_DEPTH);
      end else begin
        lane_pos[b] = lane_sum[b];
      end
      lane_waddr[b] = tbpq_pkg::ADDR_W'(b * tbpq_pkg::FIFO_DEPTH)
                    + tbpq_pkg::ADDR_W'(lane_pos[b][tbpq_pkg::PTR_W-1:0]);
      lane_raddr[b] = tbpq_pkg::ADDR_W'(b * tbpq_pkg::FIFO_DEPTH)
                    + tbpq_pkg::ADDR_W'(head_q[b]);
    end
  end

  // Pick the lowest-numbered non-empty band
  always_comb begin
    serve_found = 1'b0;
    serve_band  = tbpq_pkg::BAND_HIGH;
    for (int b = tbpq_pkg::NUM_BANDS - 1; b >= 0; b--) begin
      if (fill_q[b] != '0) begin
        serve_found = 1'b1;
        serve_band  = tbpq_pkg::BAND_W'(b);
      end
    end
  end

  // Select the lane that the request targets
  always_comb begin
    enq_full   = 1'b0;
    enq_addr   = '0;
    serve_addr = '0;
    for (int b = 0; b < tbpq_pkg::NUM_BANDS; b++) begin
      if (band_i == tbpq_pkg::BAND_W'(b)) begin
        enq_full = lane_full[b];
        enq_addr = lane_waddr[b];
      end
      if (serve_band == tbpq_pkg::BAND_W'(b)) begin
        serve_addr = lane_raddr[b];
      end
    end
  end

  // Decide the outcome, next pointers and store access
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = enq_addr;
    mem_req_o.wdata = packet_id_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = serve_addr;
    result_o.status     = tbpq_pkg::ST_EMPTY;
    result_o.band       = tbpq_pkg::BAND_HIGH;
    result_o.packet_out = '0;
    if (is_enq) begin
      result_o.band = band_i;
      if (enq_full) begin
        result_o.status = tbpq_pkg::ST_DROPPED;
      end else begin
        result_o.status = tbpq_pkg::ST_ENQUEUED;
        mem_req_o.we    = accept_i;
        for (int b = 0; b < tbpq_pkg::NUM_BANDS; b++) begin
          if (band_i == tbpq_pkg::BAND_W'(b)) begin
            fill_d[b] = fill_q[b] + tbpq_pkg::CNT_W'(1);
          end
        end
      end
    end else if (serve_found) begin
      result_o.status = tbpq_pkg::ST_ITEM;
      result_o.band   = serve_band;
      mem_req_o.re    = accept_i;
      if (is_deq) begin
        for (int b = 0; b < tbpq_pkg::NUM_BANDS; b++) begin
          if (serve_band == tbpq_pkg::BAND_W'(b)) begin
            fill_d[b] = fill_q[b] - tbpq_pkg::CNT_W'(1);
            if (head_q[b] == tbpq_pkg::PTR_W'(tbpq_pkg::FIFO_DEPTH - 1)) begin
              head_d[b] = '0;
            end else begin
              head_d[b] = head_q[b] + tbpq_pkg::PTR_W'(1);
            end
          end
        end
      end
    end
    result_o.count_band0 = tbpq_pkg::COUNT_OUT_W'(fill_d[0]);
    result_o.count_band1 = tbpq_pkg::COUNT_OUT_W'(fill_d[1]);
    result_o.count_band2 = tbpq_pkg::COUNT_OUT_W'(fill_d[2]);
  end

  // Commit pointers and counts on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < tbpq_pkg::NUM_BANDS; b++) begin
        head_q[b] <= '0;
        fill_q[b] <= '0;
      end
    end else if (accept_i) begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

endmodule
